// ----- rtl/bayer_defective_pixel_correct_top_assert.svh -----
// Assertion macros for the defective pixel correction block.
// Used by the port checker; expects aclk and aresetn in scope.
`ifndef BAYER_DEFECTIVE_PIXEL_CORRECT_TOP_ASSERT_SVH
`define BAYER_DEFECTIVE_PIXEL_CORRECT_TOP_ASSERT_SVH

// same-cycle implication
`define BDPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bdpc_pkg.sv -----
// Shared types and constants of the defective pixel correction block.
// No dependencies.
package bdpc_pkg;

    localparam int FIELD_W    = 16;
    localparam int NUM_PIX    = 9;
    localparam int S_TDATA_W  = FIELD_W * NUM_PIX;
    localparam int M_TDATA_W  = FIELD_W;
    localparam int M_TUSER_W  = 3;
    localparam int RATIO_W    = 4;
    localparam int SPREAD_W   = 20;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [RATIO_W-1:0]  AXIS_RATIO_RST   = 4'd4;
    localparam logic [RATIO_W-1:0]  DIAG_RATIO_RST   = 4'd3;
    localparam logic [SPREAD_W-1:0] SPREAD_LIMIT_RST = 20'd100;

    typedef enum logic [1:0] {
        REG_AXIS_RATIO   = 2'd0,
        REG_DIAG_RATIO   = 2'd1,
        REG_SPREAD_LIMIT = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIR_H   = 2'd0,
        DIR_V   = 2'd1,
        DIR_45  = 2'd2,
        DIR_135 = 2'd3
    } dir_t;

    typedef struct packed {
        logic [RATIO_W-1:0]  axis_ratio;
        logic [RATIO_W-1:0]  diag_ratio;
        logic [SPREAD_W-1:0] spread_limit;
    } cfg_t;

endpackage

// ----- rtl/bdpc_grad.sv -----
// Stage one: widens the window pixels, forms twelve gradients and four candidate
// replacement values. Depends on nothing outside this file.
module bdpc_grad #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [8:0][PIXEL_BITS-1:0]     pix_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [11:0][PIXEL_BITS:0]      grad_out,
    output logic [3:0][PIXEL_BITS-1:0]     cand_out,
    output logic [PIXEL_BITS-1:0]          center_out
);

    localparam int P  = PIXEL_BITS;
    localparam int GW = P + 1;
    localparam int SW = P + 3;

    function automatic logic [GW-1:0] absg(input logic signed [SW-1:0] v);
        logic [SW-1:0] m;
        m = (v < 0) ? -v : v;
        return m[GW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] halfv(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] rnd;
        rnd = $signed({{(SW-1){1'b0}}, v[SW-1]});
        return (v + rnd) >>> 1;
    endfunction

    function automatic logic [P-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] pmax;
        pmax = $signed({{(SW-P){1'b0}}, {P{1'b1}}});
        if (v < 0) begin
            return '0;
        end else if (v > pmax) begin
            return {P{1'b1}};
        end
        return v[P-1:0];
    endfunction

    function automatic logic signed [SW-1:0] ext(input logic [P-1:0] p);
        return $signed({{(SW-P){1'b0}}, p});
    endfunction

    logic signed [SW-1:0] c, ul, u, ur, l, r, dl, d, dr;
    logic signed [SW-1:0] t45, t135;
    logic [11:0][GW-1:0] grad_next;
    logic [3:0][P-1:0]   cand_next;
    logic [11:0][GW-1:0] grad_reg;
    logic [3:0][P-1:0]   cand_reg;
    logic [P-1:0]        center_reg;
    logic                valid_reg;
    logic                load;

    always_comb begin
        c  = ext(pix_in[0]);
        ul = ext(pix_in[1]);
        u  = ext(pix_in[2]);
        ur = ext(pix_in[3]);
        l  = ext(pix_in[4]);
        r  = ext(pix_in[5]);
        dl = ext(pix_in[6]);
        d  = ext(pix_in[7]);
        dr = ext(pix_in[8]);

        grad_next[0]  = absg(ul + ur - u - u);
        grad_next[1]  = absg(l + r - c - c);
        grad_next[2]  = absg(dl + dr - d - d);
        grad_next[3]  = absg(ul + dl - l - l);
        grad_next[4]  = absg(u + d - c - c);
        grad_next[5]  = absg(ur + dr - r - r);
        grad_next[6]  = absg(u + u - l - l);
        grad_next[7]  = absg(ur + dl - c - c);
        grad_next[8]  = absg(r + r - d - d);
        grad_next[9]  = absg(u + u - r - r);
        grad_next[10] = absg(ul + dr - c - c);
        grad_next[11] = absg(l + l - d - d);

        t45  = halfv(l + d - u - r);
        t135 = halfv(r + dl - u - l);

        cand_next[0] = (absg(l - c) < absg(c - r)) ? sat(l + halfv(u + d - ul - dl))
                                                   : sat(r + halfv(u + d - ur - dr));
        cand_next[1] = (absg(u - c) < absg(c - d)) ? sat(u + halfv(l + r - ul - ur))
                                                   : sat(d + halfv(l + r - dl - dr));
        cand_next[2] = (absg(ur - c) < absg(c - dl)) ? sat(ur + t45) : sat(dl - t45);
        cand_next[3] = (absg(ul - c) < absg(c - dr)) ? sat(ul + t135) : sat(dr - t135);
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            grad_reg   <= grad_next;
            cand_reg   <= cand_next;
            center_reg <= pix_in[0];
        end
    end

    assign out_valid  = valid_reg;
    assign grad_out   = grad_reg;
    assign cand_out   = cand_reg;
    assign center_out = center_reg;

endmodule

// ----- rtl/bdpc_test.sv -----
// Stage two: medians of the gradient triples, dominance and spread tests.
// Depends on bdpc_pkg for the register set type.
module bdpc_test #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bdpc_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [11:0][PIXEL_BITS:0]      grad_in,
    input  logic [3:0][PIXEL_BITS-1:0]     cand_in,
    input  logic [PIXEL_BITS-1:0]          center_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [3:0][PIXEL_BITS:0]       med_out,
    output logic [3:0]                     fix_out,
    output logic [3:0][PIXEL_BITS-1:0]     cand_out,
    output logic [PIXEL_BITS-1:0]          center_out
);

    localparam int P   = PIXEL_BITS;
    localparam int GW  = P + 1;
    localparam int PW  = GW + 1 + bdpc_pkg::RATIO_W;
    localparam int SPW = GW + 2;
    localparam int CW  = (SPW > bdpc_pkg::SPREAD_W) ? SPW : bdpc_pkg::SPREAD_W;

    function automatic logic [GW-1:0] med3(input logic [GW-1:0] a, input logic [GW-1:0] b,
                                           input logic [GW-1:0] c);
        logic [GW-1:0] hi;
        logic [GW-1:0] lo;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        if (c >= hi) begin
            return hi;
        end else if (c <= lo) begin
            return lo;
        end
        return c;
    endfunction

    function automatic logic [SPW-1:0] adiff(input logic [GW-1:0] a, input logic [GW-1:0] b);
        logic [GW-1:0] m;
        m = (a > b) ? (a - b) : (b - a);
        return SPW'(m);
    endfunction

    function automatic logic [CW-1:0] spread3(input logic [GW-1:0] a, input logic [GW-1:0] b,
                                              input logic [GW-1:0] c);
        logic [SPW-1:0] s;
        s = adiff(a, b) + adiff(a, c) + adiff(b, c);
        return CW'(s);
    endfunction

    logic [3:0][GW-1:0] med_next;
    logic [3:0]         dom;
    logic [3:0][PW-1:0] prod;
    logic [3:0]         fix_next;
    logic               spread_a_hi, spread_b_hi;
    logic [3:0][GW-1:0] med_reg;
    logic [3:0]         fix_reg;
    logic [3:0][P-1:0]  cand_reg;
    logic [P-1:0]       center_reg;
    logic               valid_reg;
    logic               load;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            med_next[k] = med3(grad_in[3*k], grad_in[3*k+1], grad_in[3*k+2]);
            prod[k] = (PW'(grad_in[3*k]) + PW'(grad_in[3*k+2]))
                    * PW'((k < 2) ? cfg.axis_ratio : cfg.diag_ratio);
            dom[k]  = PW'(grad_in[3*k+1]) > prod[k];
        end
        spread_a_hi = spread3(grad_in[6], grad_in[7], grad_in[8]) > CW'(cfg.spread_limit);
        spread_b_hi = spread3(grad_in[9], grad_in[10], grad_in[11]) > CW'(cfg.spread_limit);
        fix_next[0] = dom[0];
        fix_next[1] = dom[1];
        fix_next[2] = spread_b_hi ? (dom[2] && dom[3]) : dom[2];
        fix_next[3] = spread_a_hi ? (dom[3] && dom[2]) : dom[3];
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            med_reg    <= med_next;
            fix_reg    <= fix_next;
            cand_reg   <= cand_in;
            center_reg <= center_in;
        end
    end

    assign out_valid  = valid_reg;
    assign med_out    = med_reg;
    assign fix_out    = fix_reg;
    assign cand_out   = cand_reg;
    assign center_out = center_reg;

endmodule

// ----- rtl/bdpc_select.sv -----
// Stage three: picks the direction of least median and the output pixel.
// Depends on bdpc_pkg for the direction codes; its register is the output.
module bdpc_select #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [3:0][PIXEL_BITS:0]       med_in,
    input  logic [3:0]                     fix_in,
    input  logic [3:0][PIXEL_BITS-1:0]     cand_in,
    input  logic [PIXEL_BITS-1:0]          center_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [PIXEL_BITS-1:0]          pixel_out,
    output logic                           fixed_out,
    output bdpc_pkg::dir_t                 dir_out
);

    localparam int P = PIXEL_BITS;

    logic [1:0]     best;
    bdpc_pkg::dir_t dir_next;
    logic [P-1:0]   pixel_next;
    logic           fixed_next;
    logic [P-1:0]   pixel_reg;
    logic           fixed_reg;
    bdpc_pkg::dir_t dir_reg;
    logic           valid_reg;
    logic           load;

    always_comb begin
        best = 2'd0;
        for (int k = 1; k < 4; k++) begin
            if (med_in[k] < med_in[best]) begin
                best = 2'(k);
            end
        end
        dir_next   = bdpc_pkg::dir_t'(best);
        fixed_next = fix_in[best];
        pixel_next = fixed_next ? cand_in[best] : center_in;
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pixel_reg <= pixel_next;
            fixed_reg <= fixed_next;
            dir_reg   <= dir_next;
        end
    end

    assign out_valid = valid_reg;
    assign pixel_out = pixel_reg;
    assign fixed_out = fixed_reg;
    assign dir_out   = dir_reg;

endmodule

// ----- rtl/bayer_defective_pixel_correct_top.sv -----
// Top level of the defective pixel correction block: APB registers and
// three pipeline stages. Depends on bdpc_pkg, bdpc_grad, bdpc_test, bdpc_select.
//
// Use: each s_ item carries one same-color 3x3 window (center and the eight
// neighbors two photosites away); each m_ item carries the center pixel,
// either passed through or replaced, plus the corrected flag and the
// winning gradient direction.
// Path: an accepted item is registered in turn by the gradient stage, the
// median/test stage and the select stage, whose register is the output.
// Throughput: one item per cycle while m_tready is high; each stage holds
// one item, takes the next whenever it is empty or its successor takes its item.
// Stall: while m_tready is low the output item holds; the earlier stages
// keep filling until all three hold an item, then s_tready drops.
// Reset: aresetn low clears all stage valid bits and loads the registers
// with axis_ratio 4, diagonal_ratio 3, spread_limit 100.
// Registers: 0x0 axis_ratio, 0x4 diagonal_ratio, 0x8 spread_limit; write
// only while no item is in flight.
module bayer_defective_pixel_correct_top #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // center, up_left, up, up_right, left, right, down_left, down, down_right
    input  logic [bdpc_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_out
    output logic [bdpc_pkg::M_TDATA_W-1:0]      m_tdata,
    // was_corrected, min_direction[1:0]
    output logic [bdpc_pkg::M_TUSER_W-1:0]      m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bdpc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bdpc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bdpc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int P  = PIXEL_BITS;
    localparam int FW = bdpc_pkg::FIELD_W;

    bdpc_pkg::cfg_t     cfg_reg;
    bdpc_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    logic [8:0][P-1:0]   pix;
    logic                a_valid, a_ready;
    logic [11:0][P:0]    a_grad;
    logic [3:0][P-1:0]   a_cand;
    logic [P-1:0]        a_center;
    logic                b_valid, b_ready;
    logic [3:0][P:0]     b_med;
    logic [3:0]          b_fix;
    logic [3:0][P-1:0]   b_cand;
    logic [P-1:0]        b_center;
    logic [P-1:0]        c_pixel;
    logic                c_fixed;
    bdpc_pkg::dir_t      c_dir;

    assign pready  = 1'b1;
    assign reg_idx = bdpc_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_ratio   <= bdpc_pkg::AXIS_RATIO_RST;
            cfg_reg.diag_ratio   <= bdpc_pkg::DIAG_RATIO_RST;
            cfg_reg.spread_limit <= bdpc_pkg::SPREAD_LIMIT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                bdpc_pkg::REG_AXIS_RATIO:
                    cfg_reg.axis_ratio <= pwdata[bdpc_pkg::RATIO_W-1:0];
                bdpc_pkg::REG_DIAG_RATIO:
                    cfg_reg.diag_ratio <= pwdata[bdpc_pkg::RATIO_W-1:0];
                bdpc_pkg::REG_SPREAD_LIMIT:
                    cfg_reg.spread_limit <= pwdata[bdpc_pkg::SPREAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bdpc_pkg::REG_AXIS_RATIO:
                prdata = bdpc_pkg::APB_DATA_W'(cfg_reg.axis_ratio);
            bdpc_pkg::REG_DIAG_RATIO:
                prdata = bdpc_pkg::APB_DATA_W'(cfg_reg.diag_ratio);
            bdpc_pkg::REG_SPREAD_LIMIT:
                prdata = bdpc_pkg::APB_DATA_W'(cfg_reg.spread_limit);
            default:
                prdata = '0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < bdpc_pkg::NUM_PIX; i++) begin
            pix[i] = s_tdata[i*FW +: P];
        end
    end

    bdpc_grad #(.PIXEL_BITS(PIXEL_BITS)) u_grad (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .pix_in     (pix),
        .out_valid  (a_valid),
        .out_ready  (a_ready),
        .grad_out   (a_grad),
        .cand_out   (a_cand),
        .center_out (a_center)
    );

    bdpc_test #(.PIXEL_BITS(PIXEL_BITS)) u_test (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (a_valid),
        .in_ready   (a_ready),
        .grad_in    (a_grad),
        .cand_in    (a_cand),
        .center_in  (a_center),
        .out_valid  (b_valid),
        .out_ready  (b_ready),
        .med_out    (b_med),
        .fix_out    (b_fix),
        .cand_out   (b_cand),
        .center_out (b_center)
    );

    bdpc_select #(.PIXEL_BITS(PIXEL_BITS)) u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .med_in    (b_med),
        .fix_in    (b_fix),
        .cand_in   (b_cand),
        .center_in (b_center),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .pixel_out (c_pixel),
        .fixed_out (c_fixed),
        .dir_out   (c_dir)
    );

    assign m_tdata = bdpc_pkg::M_TDATA_W'(c_pixel);
    assign m_tuser = {c_dir, c_fixed};

endmodule

// ----- rtl/bdpc_checker.sv -----
// Port checker for the defective pixel correction top level, with its bind.
// Depends on bdpc_pkg and bayer_defective_pixel_correct_top_assert.svh.
`include "bayer_defective_pixel_correct_top_assert.svh"

module bdpc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bdpc_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [bdpc_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                            pready
);

    `BDPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output item changed")
    `BDPC_ASSERT_IMP(a_empty_after_reset, $rose(aresetn), !m_tvalid, "output item valid right after reset")
    `BDPC_ASSERT_IMP(a_ready_when_drained, !m_tvalid, s_tready, "input stalled while output is empty")
    `BDPC_ASSERT_IMP(a_input_needs_room, s_tvalid && !s_tready, m_tvalid && !m_tready, "input stalled without an output stall")

    logic pready_low;
    assign pready_low = !pready;

    `BDPC_ASSERT_IMP(a_pready_high, 1'b1, !pready_low, "pready dropped")

endmodule

bind bayer_defective_pixel_correct_top bdpc_checker u_bdpc_checker (.*);

// ----- tb/sv/bayer_defective_pixel_correct_top_tb.sv -----
// Self-checking bench for the Bayer defective pixel correction top: streams 3x3
// same-color windows, predicts each output pixel, flag and direction, checks
// them in order. Depends on bdpc_pkg and bayer_defective_pixel_correct_top.
module bayer_defective_pixel_correct_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PIXEL_BITS      = 16;
    localparam longint PIX_MAX         = (longint'(1) << PIXEL_BITS) - 1;
    localparam int     NUM_PHASES      = 6;
    localparam int     ITEMS_PER_PHASE = 250;
    localparam int     CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic [15:0] dr;
        logic [15:0] d;
        logic [15:0] dl;
        logic [15:0] r;
        logic [15:0] l;
        logic [15:0] ur;
        logic [15:0] u;
        logic [15:0] ul;
        logic [15:0] c;
    } window_t;

    typedef struct packed {
        logic [15:0]    pixel;
        logic           corrected;
        bdpc_pkg::dir_t dir;
    } pixel_result_t;

    typedef struct {
        window_t       w;
        bit            preset;
        pixel_result_t want;
    } probe_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bdpc_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bdpc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [bdpc_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [bdpc_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [bdpc_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [bdpc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    bdpc_pkg::cfg_t model_cfg = '{axis_ratio: 4'd4, diag_ratio: 4'd3, spread_limit: 20'd100};
    pixel_result_t  awaited_pixels[$];
    probe_t         directed_rows[$];
    pixel_result_t  got;
    pixel_result_t  want_now;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             hold_left = 0;
    int             cycle_count = 0;
    int             error_count = 0;
    int             windows_sent = 0;
    int             pixels_checked = 0;
    int             corrected_seen = 0;
    int             dir_count[4] = '{0, 0, 0, 0};

    bayer_defective_pixel_correct_top #(
        .PIXEL_BITS(PIXEL_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint mid_of3(input longint a, input longint b, input longint c);
        longint hi;
        longint lo;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        if (c >= hi) return hi;
        if (c <= lo) return lo;
        return c;
    endfunction

    function automatic longint halve(input longint v);
        return (v < 0) ? -((-v) / 2) : v / 2;
    endfunction

    function automatic longint spread_of3(input longint a, input longint b, input longint c);
        return mag(a - b) + mag(a - c) + mag(b - c);
    endfunction

    function automatic pixel_result_t correct_pixel(input window_t w, input bdpc_pkg::cfg_t cfg);
        longint c, ul, u, ur, l, r, dl, d, dr;
        longint h1, h2, h3, v1, v2, v3, a1, a2, a3, b1, b2, b3;
        longint med [4];
        longint ar, drt, lim, val, t;
        int best;
        bit fix, own, other_ok;
        pixel_result_t res;
        c  = longint'(w.c) & PIX_MAX;
        ul = longint'(w.ul) & PIX_MAX;
        u  = longint'(w.u) & PIX_MAX;
        ur = longint'(w.ur) & PIX_MAX;
        l  = longint'(w.l) & PIX_MAX;
        r  = longint'(w.r) & PIX_MAX;
        dl = longint'(w.dl) & PIX_MAX;
        d  = longint'(w.d) & PIX_MAX;
        dr = longint'(w.dr) & PIX_MAX;
        ar  = longint'(cfg.axis_ratio);
        drt = longint'(cfg.diag_ratio);
        lim = longint'(cfg.spread_limit);

        h1 = mag(ul + ur - 2 * u);
        h2 = mag(l + r - 2 * c);
        h3 = mag(dl + dr - 2 * d);
        v1 = mag(ul + dl - 2 * l);
        v2 = mag(u + d - 2 * c);
        v3 = mag(ur + dr - 2 * r);
        a1 = 2 * mag(u - l);
        a2 = mag(ur + dl - 2 * c);
        a3 = 2 * mag(r - d);
        b1 = 2 * mag(u - r);
        b2 = mag(ul + dr - 2 * c);
        b3 = 2 * mag(l - d);

        med[bdpc_pkg::DIR_H]   = mid_of3(h1, h2, h3);
        med[bdpc_pkg::DIR_V]   = mid_of3(v1, v2, v3);
        med[bdpc_pkg::DIR_45]  = mid_of3(a1, a2, a3);
        med[bdpc_pkg::DIR_135] = mid_of3(b1, b2, b3);
        best = 0;
        for (int k = 1; k < 4; k++) begin
            if (med[k] < med[best]) best = k;
        end

        fix = 1'b0;
        val = c;
        case (bdpc_pkg::dir_t'(best))
            bdpc_pkg::DIR_H: begin
                if (h2 > ar * (h1 + h3)) begin
                    fix = 1'b1;
                    if (mag(l - c) < mag(c - r)) val = l + halve(u + d - ul - dl);
                    else val = r + halve(u + d - ur - dr);
                end
            end
            bdpc_pkg::DIR_V: begin
                if (v2 > ar * (v1 + v3)) begin
                    fix = 1'b1;
                    if (mag(u - c) < mag(c - d)) val = u + halve(l + r - ul - ur);
                    else val = d + halve(l + r - dl - dr);
                end
            end
            bdpc_pkg::DIR_45: begin
                own      = a2 > drt * (a1 + a3);
                other_ok = b2 > drt * (b1 + b3);
                fix = (spread_of3(b1, b2, b3) > lim) ? (own && other_ok) : own;
                if (fix) begin
                    t = halve(l + d - u - r);
                    if (mag(ur - c) < mag(c - dl)) val = ur + t;
                    else val = dl - t;
                end
            end
            default: begin
                own      = b2 > drt * (b1 + b3);
                other_ok = a2 > drt * (a1 + a3);
                fix = (spread_of3(a1, a2, a3) > lim) ? (own && other_ok) : own;
                if (fix) begin
                    t = halve(r + dl - u - l);
                    if (mag(ul - c) < mag(c - dr)) val = ul + t;
                    else val = dr - t;
                end
            end
        endcase

        if (val < 0) val = 0;
        if (val > PIX_MAX) val = PIX_MAX;
        res.pixel     = val[15:0];
        res.corrected = fix;
        res.dir       = bdpc_pkg::dir_t'(best);
        return res;
    endfunction

    function automatic window_t make_window(input longint c, input longint ul,
                                            input longint u, input longint ur,
                                            input longint l, input longint r,
                                            input longint dl, input longint d,
                                            input longint dr);
        window_t w;
        w.c  = 16'(c);
        w.ul = 16'(ul);
        w.u  = 16'(u);
        w.ur = 16'(ur);
        w.l  = 16'(l);
        w.r  = 16'(r);
        w.dl = 16'(dl);
        w.d  = 16'(d);
        w.dr = 16'(dr);
        return w;
    endfunction

    // Mostly smooth windows built along one orientation, optionally with a
    // center spike or one broken neighbor; the rest is raw noise.
    function automatic window_t random_window();
        int xs [9] = '{0, -1, 0, 1, -1, 1, -1, 0, 1};
        int ys [9] = '{0, -1, -1, -1, 0, 0, 1, 1, 1};
        longint f [5];
        longint px [9];
        longint base, amp, noise, spike;
        int pos;
        bdpc_pkg::dir_t orient;
        if ($urandom_range(0, 99) < 20) begin
            return make_window($urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom);
        end
        case ($urandom_range(0, 3))
            0: base = longint'($urandom_range(0, 1000));
            1: base = 65535 - longint'($urandom_range(0, 1000));
            default: base = longint'($urandom_range(0, 65535));
        endcase
        amp = (longint'(1) << $urandom_range(0, 16)) - 1;
        for (int i = 0; i < 5; i++) begin
            f[i] = base + longint'($urandom_range(0, 32'(2 * amp))) - amp;
        end
        noise = ($urandom_range(0, 2) == 0) ? 0 : (longint'(1) << $urandom_range(0, 10)) - 1;
        orient = bdpc_pkg::dir_t'($urandom_range(0, 3));
        for (int i = 0; i < 9; i++) begin
            case (orient)
                bdpc_pkg::DIR_H:  pos = ys[i];
                bdpc_pkg::DIR_V:  pos = xs[i];
                bdpc_pkg::DIR_45: pos = xs[i] + ys[i];
                default:          pos = xs[i] - ys[i];
            endcase
            px[i] = f[pos + 2] + longint'($urandom_range(0, 32'(2 * noise))) - noise;
        end
        if ($urandom_range(0, 99) < 60) begin
            spike = longint'(1) << $urandom_range(4, 16);
            px[0] = $urandom_range(0, 1) ? px[0] + spike : px[0] - spike;
        end
        if ($urandom_range(0, 9) == 0) begin
            px[$urandom_range(1, 8)] = longint'($urandom_range(0, 65535));
        end
        for (int i = 0; i < 9; i++) begin
            if (px[i] < 0) px[i] = 0;
            if (px[i] > 65535) px[i] = 65535;
        end
        return make_window(px[0], px[1], px[2], px[3], px[4], px[5], px[6], px[7], px[8]);
    endfunction

    task automatic add_row(input window_t w, input bit preset = 1'b0,
                           input pixel_result_t want = '0);
        probe_t row;
        row.w      = w;
        row.preset = preset;
        row.want   = want;
        directed_rows = {directed_rows, row};
    endtask

    task automatic send_window(input window_t w, input pixel_result_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = w;
        do @(posedge aclk); while (!s_tready);
        awaited_pixels = {awaited_pixels, want};
        windows_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input bdpc_pkg::reg_idx_t idx, input logic [31:0] value);
        logic [31:0] keep;
        keep = (idx == bdpc_pkg::REG_SPREAD_LIMIT) ? 32'h000F_FFFF : 32'h0000_000F;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = (value & keep) | ($urandom & ~keep);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            bdpc_pkg::REG_AXIS_RATIO: model_cfg.axis_ratio   = value[3:0];
            bdpc_pkg::REG_DIAG_RATIO: model_cfg.diag_ratio   = value[3:0];
            default:                  model_cfg.spread_limit = value[19:0];
        endcase
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== (value & keep)) begin
            $display("%t: register %s readback expected %h, got %h",
                     $time, idx.name(), value & keep, prdata);
            error_count++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.pixel     = m_tdata;
            got.corrected = m_tuser[0];
            got.dir       = bdpc_pkg::dir_t'(m_tuser[2:1]);
            if (awaited_pixels.size() == 0) begin
                $display("%t: unexpected item pixel=%h corrected=%0d dir=%0d",
                         $time, got.pixel, got.corrected, got.dir);
                error_count++;
            end else begin
                want_now = awaited_pixels.pop_front();
                if (got.pixel !== want_now.pixel || got.corrected !== want_now.corrected
                        || got.dir !== want_now.dir) begin
                    $display("%t: expected pixel=%h corrected=%0d dir=%0d, got pixel=%h corrected=%0d dir=%0d",
                             $time, want_now.pixel, want_now.corrected, want_now.dir,
                             got.pixel, got.corrected, got.dir);
                    error_count++;
                end
                pixels_checked++;
                if (got.corrected === 1'b1) corrected_seen++;
                if (!$isunknown(m_tuser[2:1])) dir_count[m_tuser[2:1]]++;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int axis_set [NUM_PHASES];
        int diag_set [NUM_PHASES];
        int spread_set [NUM_PHASES];
        window_t w;

        axis_set   = '{4, 15, 1, 0, 7, 0};
        diag_set   = '{3, 15, 1, 0, 2, 0};
        spread_set = '{100, 20'hFFFFF, 0, 0, 500, 0};
        axis_set[NUM_PHASES-1]   = $urandom_range(0, 15);
        diag_set[NUM_PHASES-1]   = $urandom_range(0, 15);
        spread_set[NUM_PHASES-1] = $urandom_range(0, 20'hFFFFF);

        add_row(make_window(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                pixel_result_t'{16'd0, 1'b0, bdpc_pkg::DIR_H});
        add_row(make_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
                pixel_result_t'{16'hFFFF, 1'b0, bdpc_pkg::DIR_H});
        add_row(make_window(16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                pixel_result_t'{16'd0, 1'b1, bdpc_pkg::DIR_H});
        add_row(make_window(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
                pixel_result_t'{16'hFFFF, 1'b1, bdpc_pkg::DIR_H});
        add_row(make_window(1000, 0, 1000, 0, 0, 0, 0, 1000, 0));
        add_row(make_window(5000, 0, 1000, 0, 0, 0, 0, 1000, 0));
        add_row(make_window(5000, 0, 4000, 0, 0, 0, 0, 1000, 0));
        add_row(make_window(9000, 100, 100, 100, 8000, 3000, 200, 200, 200));
        add_row(make_window(9000, 100, 100, 100, 3000, 8000, 200, 200, 200));
        add_row(make_window(2000, 0, 800, 2000, 800, 800, 2000, 800, 0));
        add_row(make_window(30000, 0, 800, 2000, 800, 800, 2000, 800, 0));
        add_row(make_window(30000, 0, 800, 2000, 800, 800, 29000, 800, 0));
        add_row(make_window(20000, 3000, 900, 0, 900, 900, 0, 900, 3000));
        add_row(make_window(0, 3000, 900, 0, 900, 900, 0, 900, 2500));
        add_row(make_window(0, 16'hFFFF, 40000, 16'hFFFF, 40000, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 16'hFFFF));
        add_row(make_window(16'hFFFF, 0, 30000, 0, 30000, 0, 0, 0, 0));
        add_row(make_window(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                            16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        add_row(make_window(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                            16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        add_row(make_window(16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF));

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                while (awaited_pixels.size() != 0) @(posedge aclk);
                repeat (4) @(negedge aclk);
                write_reg(bdpc_pkg::REG_AXIS_RATIO, axis_set[phase]);
                write_reg(bdpc_pkg::REG_DIAG_RATIO, diag_set[phase]);
                write_reg(bdpc_pkg::REG_SPREAD_LIMIT, spread_set[phase]);
            end
            send_idle_pct = (phase < 2) ? 34 : (phase < 4) ? 54 : 0;
            recv_idle_pct = (phase < 2) ? 54 : (phase < 4) ? 34 : 0;
            if (phase == 4) hold_left = 80;
            if (phase == 0) begin
                foreach (directed_rows[i]) begin
                    send_window(directed_rows[i].w, directed_rows[i].preset ?
                                directed_rows[i].want : correct_pixel(directed_rows[i].w, model_cfg));
                end
            end
            repeat (ITEMS_PER_PHASE) begin
                w = random_window();
                send_window(w, correct_pixel(w, model_cfg));
            end
            s_tvalid = 1'b0;
        end

        while (awaited_pixels.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Streamed %0d windows under %0d register settings, %0d results checked, %0d corrected.",
                 windows_sent, NUM_PHASES, pixels_checked, corrected_seen);
        $display("Winning directions: horizontal %0d, vertical %0d, 45 deg %0d, 135 deg %0d.",
                 dir_count[0], dir_count[1], dir_count[2], dir_count[3]);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
